// ----- rtl/core/fsmf_pkg.sv -----
// Shared types and constants for the fraction sum block.
`default_nettype none
package fsmf_pkg;

  localparam int ACC_W  = 64;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 64;
  localparam int FORM_W = 2;
  localparam int PROD_W = ACC_W + IN_W;
  localparam int CNT_W  = $clog2(ACC_W + 1);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [FORM_W-1:0] {
    FORM_WHOLE  = 2'd0,
    FORM_PROPER = 2'd1,
    FORM_MIXED  = 2'd2
  } form_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_DIVQ,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [IN_W-1:0] num;
    logic [IN_W-1:0] den;
    logic            last;
    logic            bad;
  } item_t;

  typedef struct packed {
    form_t            form;
    logic [ACC_W-1:0] whole;
    logic [ACC_W-1:0] part_num;
    logic [ACC_W-1:0] part_den;
    logic             ovf;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
    logic [ACC_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/fraction_sum_mixed_form.sv -----
// Top level: fraction sum reduced to whole, proper or mixed form.
// Each item passes through the multiply-accumulate states MUL1 to MUL4 (one shared 64x16 multiplier).
// A last item adds (3 + k) divides on the bit-serial divider, k being the Euclid steps
// of the gcd; an exact quotient needs one divide only, a zero denominator product none.
// A two-entry input queue and one output register let both sides stall independently.
// Synchronous active-low reset empties the input queue and output register and clears the running sum to 0/1.
`default_nettype none
module fraction_sum_mixed_form (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [fsmf_pkg::IN_W-1:0]   in_numerator,
  input  logic [fsmf_pkg::IN_W-1:0]   in_denominator,
  input  logic                        in_last,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [fsmf_pkg::FORM_W-1:0] out_form,
  output logic [fsmf_pkg::OUT_W-1:0]  out_whole_part,
  output logic [fsmf_pkg::OUT_W-1:0]  out_part_numerator,
  output logic [fsmf_pkg::OUT_W-1:0]  out_part_denominator,
  output logic                        out_overflow
);
  import fsmf_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  logic    load;

  fsmf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_numerator   (in_numerator),
    .in_denominator (in_denominator),
    .in_last        (in_last),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take)
  );

  fsmf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || out_pop;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_empty            = !out_valid_r;
  assign out_form             = out_res_r.form;
  assign out_whole_part       = OUT_W'(out_res_r.whole);
  assign out_part_numerator   = OUT_W'(out_res_r.part_num);
  assign out_part_denominator = OUT_W'(out_res_r.part_den);
  assign out_overflow         = out_res_r.ovf;

endmodule
`default_nettype wire

// ----- rtl/core/fsmf_front.sv -----
// Front end: takes input requests, fixes zero denominators, queues items.
`default_nettype none
module fsmf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [fsmf_pkg::IN_W-1:0] in_numerator,
  input  logic [fsmf_pkg::IN_W-1:0] in_denominator,
  input  logic                      in_last,
  output fsmf_pkg::item_t           item,
  output logic                      item_valid,
  input  logic                      item_take
);
  import fsmf_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_ok, pop_ok;
  item_t             cls;

  assign in_full    = (cnt_r == QCNT_W'(QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_take && item_valid;

  always_comb begin
    cls.num  = in_numerator;
    cls.bad  = (in_denominator == '0);
    cls.den  = cls.bad ? IN_W'(1) : in_denominator;
    cls.last = in_last;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fsmf_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fsmf_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsmf_pkg::div_req_t   req,
  output fsmf_pkg::div_rsp_t   rsp
);
  import fsmf_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] quo_r, quo_nxt;
  logic [ACC_W-1:0] dsr_r, dsr_nxt;
  logic [ACC_W:0]   rem_sh;
  logic [ACC_W+1:0] diff;

  assign rem_sh = {rem_r, quo_r[ACC_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ACC_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[ACC_W+1]) begin
        rem_nxt = diff[ACC_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[ACC_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule
`default_nettype wire

// ----- rtl/core/fsmf_back.sv -----
// Back end: multiply-accumulate per item, then quotient, gcd and reduction.
`default_nettype none
module fsmf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fsmf_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_take,
  output fsmf_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_ready
);
  import fsmf_pkg::*;

  back_state_t       st_r, st_nxt;
  logic [ACC_W-1:0]  sum_r, sum_nxt;
  logic [ACC_W-1:0]  dprod_r, dprod_nxt;
  logic              ovf_r, ovf_nxt;
  item_t             cur_r, cur_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  tmp_r, tmp_nxt;
  logic [ACC_W-1:0]  quo_r, quo_nxt;
  logic [ACC_W-1:0]  rem_r, rem_nxt;
  logic [ACC_W-1:0]  gb_r, gb_nxt;
  logic [ACC_W-1:0]  pn_r, pn_nxt;
  result_t           res_r, res_nxt;

  logic [ACC_W-1:0]  mul_a;
  logic [IN_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod_w;
  logic [ACC_W:0]    add_w;
  logic              prod_hi;
  logic [ACC_W-1:0]  p_w;
  logic              ovf_c;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  fsmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // one shared ACC_W x IN_W multiplier
  always_comb begin
    case (st_r)
      ST_MUL2: begin
        mul_a = dprod_r;
        mul_b = cur_r.num;
      end
      ST_MUL3: begin
        mul_a = dprod_r;
        mul_b = cur_r.den;
      end
      default: begin
        mul_a = sum_r;
        mul_b = cur_r.den;
      end
    endcase
  end

  assign prod_w  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_hi = |prod_r[PROD_W-1:ACC_W];
  assign add_w   = {1'b0, tmp_r} + {1'b0, prod_r[ACC_W-1:0]};
  assign p_w     = prod_r[ACC_W-1:0];
  assign ovf_c   = ovf_r | prod_hi;

  always_comb begin
    st_nxt           = st_r;
    sum_nxt          = sum_r;
    dprod_nxt        = dprod_r;
    ovf_nxt          = ovf_r;
    cur_nxt          = cur_r;
    prod_nxt         = prod_r;
    tmp_nxt          = tmp_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    gb_nxt           = gb_r;
    pn_nxt           = pn_r;
    res_nxt          = res_r;
    item_take        = 1'b0;
    res_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tmp_r;
    div_req.divisor  = dprod_r;
    case (st_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          cur_nxt   = item;
          ovf_nxt   = ovf_r | item.bad;
          st_nxt    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt = prod_w;
        st_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        tmp_nxt  = prod_r[ACC_W-1:0];
        ovf_nxt  = ovf_c;
        prod_nxt = prod_w;
        st_nxt   = ST_MUL3;
      end
      ST_MUL3: begin
        tmp_nxt  = add_w[ACC_W-1:0];
        ovf_nxt  = ovf_c | add_w[ACC_W];
        prod_nxt = prod_w;
        st_nxt   = ST_MUL4;
      end
      ST_MUL4: begin
        dprod_nxt = p_w;
        ovf_nxt   = ovf_c;
        if (!cur_r.last) begin
          sum_nxt = tmp_r;
          if (item_valid) begin
            item_take = 1'b1;
            cur_nxt   = item;
            ovf_nxt   = ovf_c | item.bad;
            st_nxt    = ST_MUL1;
          end else begin
            st_nxt = ST_IDLE;
          end
        end else if (p_w == '0) begin
          res_nxt.form     = FORM_WHOLE;
          res_nxt.whole    = '0;
          res_nxt.part_num = '0;
          res_nxt.part_den = '0;
          res_nxt.ovf      = ovf_c;
          st_nxt           = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = tmp_r;
          div_req.divisor  = p_w;
          st_nxt           = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        if (div_rsp.done) begin
          quo_nxt = div_rsp.quo;
          rem_nxt = div_rsp.rem;
          if (div_rsp.rem == '0) begin
            res_nxt.form     = FORM_WHOLE;
            res_nxt.whole    = div_rsp.quo;
            res_nxt.part_num = '0;
            res_nxt.part_den = '0;
            res_nxt.ovf      = ovf_r;
            st_nxt           = ST_OUT;
          end else begin
            // gcd(s, p) = gcd(p, s mod p)
            gb_nxt           = div_rsp.rem;
            div_req.start    = 1'b1;
            div_req.dividend = dprod_r;
            div_req.divisor  = div_rsp.rem;
            st_nxt           = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = rem_r;
            div_req.divisor  = gb_r;
            st_nxt           = ST_DIVN;
          end else begin
            gb_nxt           = div_rsp.rem;
            div_req.start    = 1'b1;
            div_req.dividend = gb_r;
            div_req.divisor  = div_rsp.rem;
          end
        end
      end
      ST_DIVN: begin
        if (div_rsp.done) begin
          pn_nxt           = div_rsp.quo;
          div_req.start    = 1'b1;
          div_req.dividend = dprod_r;
          div_req.divisor  = gb_r;
          st_nxt           = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_rsp.done) begin
          // whole part of the reduced fraction equals s / p
          res_nxt.form     = (quo_r == '0) ? FORM_PROPER : FORM_MIXED;
          res_nxt.whole    = quo_r;
          res_nxt.part_num = pn_r;
          res_nxt.part_den = div_rsp.quo;
          res_nxt.ovf      = ovf_r;
          st_nxt           = ST_OUT;
        end
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          sum_nxt   = '0;
          dprod_nxt = ACC_W'(1);
          ovf_nxt   = 1'b0;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      sum_r   <= '0;
      dprod_r <= ACC_W'(1);
      ovf_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      sum_r   <= sum_nxt;
      dprod_r <= dprod_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prod_r <= prod_nxt;
    tmp_r  <= tmp_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    gb_r   <= gb_nxt;
    pn_r   <= pn_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

  a_whole_no_part: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.form == FORM_WHOLE) |->
      (res_r.part_num == '0 && res_r.part_den == '0))
    else $error("whole result carries a fraction part");

  a_mixed_has_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.form == FORM_MIXED) |-> (res_r.whole != '0))
    else $error("mixed result with zero whole part");

  a_part_proper: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.form != FORM_WHOLE) |->
      (res_r.part_num != '0 && res_r.part_num < res_r.part_den))
    else $error("fraction part not proper");

endmodule
`default_nettype wire

// ----- tb/fraction_sum_mixed_form_tb.sv -----
// Testbench for fraction_sum_mixed_form: directed table plus random sets, scoreboard checked.
`default_nettype none
module fraction_sum_mixed_form_tb;
  import fsmf_pkg::*;

  localparam int RAND_ITEMS     = 1100;
  localparam int PRESSURE_AT    = 400;
  localparam int PRESSURE_HOLD  = 5000;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    bit [IN_W-1:0] num;
    bit [IN_W-1:0] den;
    bit            last;
    bit            typed;
    result_t       want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [IN_W-1:0]   in_numerator;
  logic [IN_W-1:0]   in_denominator;
  logic              in_last;
  logic              out_empty;
  logic              out_pop;
  logic [FORM_W-1:0] out_form;
  logic [OUT_W-1:0]  out_whole_part;
  logic [OUT_W-1:0]  out_part_numerator;
  logic [OUT_W-1:0]  out_part_denominator;
  logic              out_overflow;

  bit [ACC_W-1:0] run_num;
  bit [ACC_W-1:0] run_den;
  bit             run_ovf;
  result_t        pending_sums[$];
  stim_row_t      dir_rows[$];
  int             mismatch_cnt = 0;
  int             calm_tx = 0;
  int             calm_rx = 0;
  bit             hold_req = 1'b0;

  fraction_sum_mixed_form uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_numerator        (in_numerator),
    .in_denominator      (in_denominator),
    .in_last             (in_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_form            (out_form),
    .out_whole_part      (out_whole_part),
    .out_part_numerator  (out_part_numerator),
    .out_part_denominator(out_part_denominator),
    .out_overflow        (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adds one fraction to the running sum; returns 1 with the reduced sum on a last request.
  function automatic bit fold_fraction(input bit [IN_W-1:0] num, input bit [IN_W-1:0] den,
                                       input bit last, output result_t res);
    bit [2*ACC_W-1:0] prod;
    bit [ACC_W:0]     tot;
    bit [ACC_W-1:0]   d, a, b, s, p, x, y, t, rs, rp;
    bit               ovf;
    res = '0;
    ovf = run_ovf;
    d = ACC_W'(den);
    if (den == 0) begin
      d = 1;
      ovf = 1'b1;
    end
    prod = {{ACC_W{1'b0}}, run_num} * {{ACC_W{1'b0}}, d};
    if (prod[2*ACC_W-1:ACC_W] != 0) ovf = 1'b1;
    a = prod[ACC_W-1:0];
    prod = {{(2*ACC_W-IN_W){1'b0}}, num} * {{ACC_W{1'b0}}, run_den};
    if (prod[2*ACC_W-1:ACC_W] != 0) ovf = 1'b1;
    b = prod[ACC_W-1:0];
    tot = {1'b0, a} + {1'b0, b};
    if (tot[ACC_W]) ovf = 1'b1;
    s = tot[ACC_W-1:0];
    prod = {{ACC_W{1'b0}}, run_den} * {{ACC_W{1'b0}}, d};
    if (prod[2*ACC_W-1:ACC_W] != 0) ovf = 1'b1;
    p = prod[ACC_W-1:0];
    if (!last) begin
      run_num = s;
      run_den = p;
      run_ovf = ovf;
      return 1'b0;
    end
    res.form = FORM_WHOLE;
    res.ovf  = ovf;
    if (p != 0) begin
      if (s % p == 0) begin
        res.whole = s / p;
      end else begin
        x = s;
        y = p;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        rs = s / x;
        rp = p / x;
        res.part_den = rp;
        if (s < p) begin
          res.form     = FORM_PROPER;
          res.part_num = rs;
        end else begin
          res.form     = FORM_MIXED;
          res.whole    = rs / rp;
          res.part_num = rs % rp;
        end
      end
    end
    run_num = 0;
    run_den = 1;
    run_ovf = 1'b0;
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic bit [IN_W-1:0] rand_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    if (r < 35) return IN_W'($urandom_range(1, 15));
    if (r < 65) return IN_W'($urandom_range(1, 255));
    return IN_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_row(input bit [IN_W-1:0] num, input bit [IN_W-1:0] den, input bit last);
    stim_row_t row;
    row.num   = num;
    row.den   = den;
    row.last  = last;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_typed(input bit [IN_W-1:0] num, input bit [IN_W-1:0] den,
                           input form_t f, input bit [ACC_W-1:0] w, input bit [ACC_W-1:0] pn,
                           input bit [ACC_W-1:0] pd, input bit o);
    stim_row_t row;
    row.num           = num;
    row.den           = den;
    row.last          = 1'b1;
    row.typed         = 1'b1;
    row.want.form     = f;
    row.want.whole    = w;
    row.want.part_num = pn;
    row.want.part_den = pd;
    row.want.ovf      = o;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic send_fraction(input bit [IN_W-1:0] num, input bit [IN_W-1:0] den,
                               input bit last, input bit typed, input result_t want);
    int      gap;
    bit      has;
    result_t res;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_numerator   <= num;
    in_denominator <= den;
    in_last        <= last;
    do @(posedge clk); while (in_full);
    has = fold_fraction(num, den, last, res);
    if (typed) pending_sums.insert(pending_sums.size(), want);
    else if (has) pending_sums.insert(pending_sums.size(), res);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR @%0t %s: got %0h want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_sum();
    result_t want;
    if (pending_sums.size() == 0) begin
      report_mismatch("unexpected result, whole_part", out_whole_part, 64'd0);
      return;
    end
    want = pending_sums.pop_front();
    if (out_form !== want.form)
      report_mismatch("form", 64'(out_form), 64'(want.form));
    if (out_whole_part !== want.whole)
      report_mismatch("whole_part", out_whole_part, want.whole);
    if (out_part_numerator !== want.part_num)
      report_mismatch("part_numerator", out_part_numerator, want.part_num);
    if (out_part_denominator !== want.part_den)
      report_mismatch("part_denominator", out_part_denominator, want.part_den);
    if (out_overflow !== want.ovf)
      report_mismatch("overflow", 64'(out_overflow), 64'(want.ovf));
  endtask

  // result side: random pops, one long hold-off on request
  initial begin
    int stall;
    int gap;
    stall   = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_sum();
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = PRESSURE_HOLD;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        gap = pick_gap(calm_rx);
        if (gap == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          stall = gap - 1;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int      sent;
    int      len;
    result_t none;
    none           = '0;
    sent           = 0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_numerator   = '0;
    in_denominator = 16'd1;
    in_last        = 1'b0;
    run_num        = 0;
    run_den        = 1;
    run_ovf        = 1'b0;

    add_typed(16'd0,     16'd1,     FORM_WHOLE,  64'd0,     64'd0, 64'd0,     1'b0);
    add_typed(16'hFFFF,  16'd1,     FORM_WHOLE,  64'd65535, 64'd0, 64'd0,     1'b0);
    add_typed(16'd1,     16'hFFFF,  FORM_PROPER, 64'd0,     64'd1, 64'd65535, 1'b0);
    add_typed(16'hFFFF,  16'hFFFF,  FORM_WHOLE,  64'd1,     64'd0, 64'd0,     1'b0);
    add_typed(16'd7,     16'd2,     FORM_MIXED,  64'd3,     64'd1, 64'd2,     1'b0);
    // zero denominator taken as one, flagged
    add_typed(16'd3,     16'd0,     FORM_WHOLE,  64'd3,     64'd0, 64'd0,     1'b1);
    add_typed(16'd0,     16'd0,     FORM_WHOLE,  64'd0,     64'd0, 64'd0,     1'b1);
    add_row(16'd1, 16'd2, 1'b0);
    add_row(16'd1, 16'd3, 1'b1);
    add_row(16'd1, 16'd4, 1'b0);
    add_row(16'd1, 16'd4, 1'b1);
    add_row(16'hFFFF, 16'd2, 1'b0);
    add_row(16'hFFFF, 16'd3, 1'b1);
    // product past 64 bits
    repeat (4) add_row(16'hFFFF, 16'hFFFF, 1'b0);
    add_row(16'hFFFF, 16'hFFFF, 1'b1);
    // product wraps to zero: 2^75
    repeat (4) add_row(16'd1, 16'd32768, 1'b0);
    add_typed(16'd1,     16'd32768, FORM_WHOLE,  64'd0,     64'd0, 64'd0,     1'b1);
    add_row(16'd40000, 16'd7, 1'b0);
    add_row(16'd12345, 16'hFFFF, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_fraction(dir_rows[i].num, dir_rows[i].den, dir_rows[i].last, dir_rows[i].typed,
                    dir_rows[i].want);

    while (sent < RAND_ITEMS) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        send_fraction(rand_operand(), rand_operand(), k == len - 1, 1'b0, none);
        sent++;
        if (sent == PRESSURE_AT) hold_req = 1'b1;
      end
    end
    in_push <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/fsmf_pkg.sv
rtl/core/fsmf_front.sv
rtl/core/fsmf_div.sv
rtl/core/fsmf_back.sv
rtl/core/fraction_sum_mixed_form.sv
tb/fraction_sum_mixed_form_tb.sv
